// ===== design/in_order_release_reorder_buffer_macros.svh =====
// Assertion macros used by the reorder buffer datapath.
`ifndef IN_ORDER_RELEASE_REORDER_BUFFER_MACROS_SVH
`define IN_ORDER_RELEASE_REORDER_BUFFER_MACROS_SVH

// Same-cycle implication.
`define ROB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ROB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rob_pkg.sv =====
// Types and constants of the reorder buffer.
package rob_pkg;

  localparam int KIND_BITS     = 2;
  localparam int CFG_BITS      = 32;
  localparam int MAX_RESULTS   = 16;
  localparam int N_BITS        = $clog2(MAX_RESULTS + 1);
  localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_REGISTER = 2'd0,
    KIND_STORE    = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_COLLECT  = 2'd3
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input ready
    logic tick;
    logic pos_inc;
    logic append;
    logic store_hit;
    logic release_hd;
    logic push_out;
    logic push_last;
  } rob_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  in_valid;
    kind_t in_kind;
    logic  in_present;
    logic  count_zero;
    logic  count_one;
    logic  full;
    logic  pos_last;
    logic  tag_match;
    logic  item_store;
    logic  head_ok;
    logic  pend_valid;
    logic  out_free;
    logic  n_limit;
  } rob_sts_t;

endpackage

// ===== design/rob_if.sv =====
// Valid/ready channel interfaces for input and result words.
interface rob_in_if import rob_pkg::*; #(
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) ();
  logic                    valid;
  logic                    ready;
  logic [KIND_BITS-1:0]    kind;
  logic                    tag_present;
  logic [TAG_BITS-1:0]     bag_tag;
  logic [PAYLOAD_BITS-1:0] result_payload;

  modport source (output valid, kind, tag_present, bag_tag, result_payload, input ready);
  modport sink   (input valid, kind, tag_present, bag_tag, result_payload, output ready);
endinterface

interface rob_out_if #(
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) ();
  logic                    valid;
  logic                    ready;
  logic [TAG_BITS-1:0]     out_tag;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    out_expired;
  logic                    last;

  modport source (output valid, out_tag, out_payload, out_expired, last, input ready);
  modport sink   (input valid, out_tag, out_payload, out_expired, last, output ready);
endinterface

// ===== design/rob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rob_ctrl.sv =====
// Sequencer: tag search, append, and in-order release walk.
module rob_ctrl import rob_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rob_sts_t sts,
  output rob_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_S_RD,
    ST_S_CMP,
    ST_APPEND,
    ST_C_RD,
    ST_C_EVAL,
    ST_FLUSH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) begin
          case (sts.in_kind)
            KIND_TICK: begin
              cmd.tick = 1'b1;
            end
            KIND_COLLECT: begin
              if (!sts.count_zero) state_next = ST_C_RD;
            end
            KIND_REGISTER, KIND_STORE: begin
              if (sts.in_present) begin
                state_next = sts.count_zero ? ST_APPEND : ST_S_RD;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_S_RD: begin
        state_next = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (sts.tag_match) begin
          cmd.store_hit = sts.item_store;
          state_next    = ST_IDLE;
        end else if (sts.pos_last) begin
          state_next = ST_APPEND;
        end else begin
          cmd.pos_inc = 1'b1;
          state_next  = ST_S_RD;
        end
      end
      ST_APPEND: begin
        // full buffer: new tag dropped
        cmd.append = !sts.full;
        state_next = ST_IDLE;
      end
      ST_C_RD: begin
        state_next = ST_C_EVAL;
      end
      ST_C_EVAL: begin
        if (sts.head_ok) begin
          if (!sts.pend_valid || sts.out_free) begin
            cmd.release_hd = 1'b1;
            cmd.push_out   = sts.pend_valid;
            state_next     = (sts.count_one || sts.n_limit) ? ST_FLUSH : ST_C_RD;
          end
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push_out  = 1'b1;
          cmd.push_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== design/rob_dp.sv =====
// Datapath: entry RAMs, FIFO pointers, ready bits, timer, pending and output words.
`include "in_order_release_reorder_buffer_macros.svh"

module rob_dp import rob_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int TIME_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  rob_in_if.sink              item,
  rob_out_if.source           result,
  input  rob_cmd_t            cmd,
  output rob_sts_t            sts
);

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int SUM_BITS = IDX_BITS + 1;
  localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  // control state
  logic [IDX_BITS-1:0]  head;
  logic [CNT_BITS-1:0]  count;
  logic [IDX_BITS-1:0]  pos;
  logic [N_BITS-1:0]    n;
  logic [DEPTH-1:0]     ready_bits;
  logic [TIME_BITS-1:0] now;
  logic [CFG_BITS-1:0]  timeout;
  logic                 pend_valid;
  logic                 out_valid;

  // latched item and word registers
  logic [TAG_BITS-1:0]     item_tag;
  logic [PAYLOAD_BITS-1:0] item_payload;
  logic                    item_store;
  logic [TAG_BITS-1:0]     pend_tag;
  logic [PAYLOAD_BITS-1:0] pend_payload;
  logic                    pend_to;
  logic [TAG_BITS-1:0]     res_tag;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic                    res_to;
  logic                    res_last;

  logic                    accept;
  logic [SUM_BITS-1:0]     rd_sum, tail_sum;
  logic [IDX_BITS-1:0]     rd_addr, tail_addr, pay_waddr;
  logic [IDX_BITS-1:0]     head_inc;
  logic [TAG_BITS-1:0]     tag_rd;
  logic [PAYLOAD_BITS-1:0] pay_rd, pay_wdata;
  logic [TIME_BITS-1:0]    time_rd, waited;
  logic                    head_ready, out_free;

  assign accept = item.valid && item.ready;

  // circular slot arithmetic
  assign rd_sum    = {1'b0, head} + {1'b0, pos};
  assign rd_addr   = (rd_sum >= SUM_BITS'(DEPTH)) ? IDX_BITS'(rd_sum - SUM_BITS'(DEPTH))
                                                  : rd_sum[IDX_BITS-1:0];
  assign tail_sum  = {1'b0, head} + SUM_BITS'(count);
  assign tail_addr = (tail_sum >= SUM_BITS'(DEPTH)) ? IDX_BITS'(tail_sum - SUM_BITS'(DEPTH))
                                                    : tail_sum[IDX_BITS-1:0];
  assign head_inc  = (head == IDX_BITS'(DEPTH - 1)) ? '0 : head + IDX_BITS'(1);

  assign pay_waddr = cmd.append ? tail_addr : rd_addr;
  assign pay_wdata = item_payload;

  rob_ram #(.WIDTH(TAG_BITS), .DEPTH(DEPTH)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail_addr),
    .wdata (item_tag),
    .raddr (rd_addr),
    .rdata (tag_rd)
  );

  rob_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (cmd.store_hit || (cmd.append && item_store)),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .raddr (rd_addr),
    .rdata (pay_rd)
  );

  rob_ram #(.WIDTH(TIME_BITS), .DEPTH(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail_addr),
    .wdata (now),
    .raddr (rd_addr),
    .rdata (time_rd)
  );

  assign head_ready = ready_bits[head];
  assign waited     = now - time_rd;
  assign out_free   = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      pos        <= '0;
      n          <= '0;
      ready_bits <= '0;
      now        <= '0;
      timeout    <= TIMEOUT_RESET;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) timeout <= cfg_wdata;
      if (cmd.tick) now <= now + TIME_BITS'(1);
      if (accept) begin
        pos <= '0;
        n   <= '0;
      end else if (cmd.pos_inc) begin
        pos <= pos + IDX_BITS'(1);
      end
      if (cmd.append) begin
        ready_bits[tail_addr] <= item_store;
        count                 <= count + CNT_BITS'(1);
      end
      if (cmd.store_hit) ready_bits[rd_addr] <= 1'b1;
      if (cmd.release_hd) begin
        ready_bits[head] <= 1'b0;
        head             <= head_inc;
        count            <= count - CNT_BITS'(1);
        n                <= n + N_BITS'(1);
      end
      if (cmd.release_hd) begin
        pend_valid <= 1'b1;
      end else if (cmd.push_out) begin
        pend_valid <= 1'b0;
      end
      if (cmd.push_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_tag     <= item.bag_tag;
      item_payload <= item.result_payload;
      item_store   <= (kind_t'(item.kind) == KIND_STORE);
    end
    if (cmd.push_out) begin
      res_tag     <= pend_tag;
      res_payload <= pend_payload;
      res_to      <= pend_to;
      res_last    <= cmd.push_last;
    end
    if (cmd.release_hd) begin
      pend_tag     <= tag_rd;
      pend_payload <= head_ready ? pay_rd : '0;
      pend_to      <= !head_ready;
    end
  end

  // no input word is taken while in reset
  assign item.ready         = cmd.take && !rst;
  assign result.valid       = out_valid;
  assign result.out_tag     = res_tag;
  assign result.out_payload = res_payload;
  assign result.out_expired = res_to;
  assign result.last        = res_last;

  always_comb begin
    sts            = '0;
    sts.in_valid   = item.valid;
    sts.in_kind    = kind_t'(item.kind);
    sts.in_present = item.tag_present;
    sts.count_zero = (count == '0);
    sts.count_one  = (count == CNT_BITS'(1));
    sts.full       = (count == CNT_BITS'(DEPTH));
    sts.pos_last   = ((CNT_BITS'(pos) + CNT_BITS'(1)) == count);
    sts.tag_match  = (tag_rd == item_tag);
    sts.item_store = item_store;
    sts.head_ok    = head_ready || (CMP_BITS'(waited) >= CMP_BITS'(timeout));
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
    sts.n_limit    = (n == N_BITS'(MAX_RESULTS - 1));
  end

  `ROB_ASSERT_IMP(a_push_free, clk, rst, cmd.push_out, out_free, "result word overwritten")
  `ROB_ASSERT_IMP(a_push_pend, clk, rst, cmd.push_out, pend_valid, "push with no pending word")
  `ROB_ASSERT_IMP(a_rel_cnt, clk, rst, cmd.release_hd, count != '0, "release from empty buffer")
  `ROB_ASSERT_NXT(a_rel_pend, clk, rst, cmd.release_hd, pend_valid, "released word not held")

endmodule

// ===== design/in_order_release_reorder_buffer.sv =====
// Steps: a tick is handled in idle; register/store searches each held entry (read, compare)
// and appends the tag if absent. Collect: head read and evaluate per released entry; an unready
// head ends the walk, then a flush if anything was held; a stalled output holds the walk mid-way.
// Throughput: one item at a time; input ready only while the sequencer is idle.
// Reset (rst, synchronous, active high): empties the FIFO, clears ready bits and timer, loads
// the timeout register with 1000; RAM contents stay undefined, no clearing pass.
module in_order_release_reorder_buffer import rob_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int TIME_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  rob_in_if.sink              item,
  rob_out_if.source           result
);

  // The controller only sequences; every stored value lives in the datapath.
  // Search: each held entry takes a RAM read state and a compare state, the
  // first match wins, no match falls through to append (dropped when full).
  // Release: the head entry goes out if ready, or as a timed-out reject
  // (payload zero) once now - entry_time reaches the timeout register. A released
  // word is held in a pending register so that the last flag can be set when the walk ends.

  rob_cmd_t cmd;
  rob_sts_t sts;

  rob_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rob_dp #(
    .DEPTH        (DEPTH),
    .TAG_BITS     (TAG_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== verif/rob_release_checker.sv =====
// Checker for the reorder buffer: predicts release words from accepted input words and compares.
module rob_release_checker import rob_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int TAG_BITS     = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int TIME_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  rob_in_if                   item,
  rob_out_if                  result,
  output int                  errors,
  output int                  pending
);

  localparam int RQ_DEPTH = 64;

  typedef struct {
    logic [TAG_BITS-1:0]     tag;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    expired;
    logic                    last;
  } release_word_t;

  // shadow of the buffer
  logic [TAG_BITS-1:0]     held_tag     [DEPTH];
  logic [PAYLOAD_BITS-1:0] held_payload [DEPTH];
  logic                    held_ready   [DEPTH];
  logic [TIME_BITS-1:0]    enrol_time   [DEPTH];
  int                      head_slot;
  int                      held_count;
  logic [TIME_BITS-1:0]    tick_now;
  logic [CFG_BITS-1:0]     timeout_ticks;

  // expected words in order, as a ring with running counters
  release_word_t release_buf [RQ_DEPTH];
  int            rq_wr     = 0;
  int            rq_rd     = 0;
  int            err_total = 0;

  function automatic int find_slot(logic [TAG_BITS-1:0] t);
    int s;
    for (int i = 0; i < held_count; i++) begin
      s = (head_slot + i) % DEPTH;
      if (held_tag[s] == t) return s;
    end
    return -1;
  endfunction

  // returns the tag's slot, appending it if absent; -1 when full
  function automatic int enrol_tag(logic [TAG_BITS-1:0] t);
    int s;
    s = find_slot(t);
    if (s >= 0) return s;
    if (held_count >= DEPTH) return -1;
    s = (head_slot + held_count) % DEPTH;
    held_tag[s]     = t;
    held_payload[s] = '0;
    held_ready[s]   = 1'b0;
    enrol_time[s]   = tick_now;
    held_count++;
    return s;
  endfunction

  function automatic void release_walk();
    release_word_t        batch [MAX_RESULTS];
    logic [TIME_BITS-1:0] waited;
    int                   n;
    n = 0;
    while (held_count > 0 && n < MAX_RESULTS) begin
      waited = tick_now - enrol_time[head_slot];
      if (held_ready[head_slot]) begin
        batch[n].payload = held_payload[head_slot];
        batch[n].expired = 1'b0;
      end else if (waited >= timeout_ticks) begin
        batch[n].payload = '0;
        batch[n].expired = 1'b1;
      end else begin
        break;
      end
      batch[n].tag  = held_tag[head_slot];
      batch[n].last = 1'b0;
      held_ready[head_slot] = 1'b0;
      head_slot = (head_slot + 1) % DEPTH;
      held_count--;
      n++;
    end
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      release_buf[rq_wr % RQ_DEPTH] = batch[i];
      rq_wr++;
    end
  endfunction

  function automatic void apply_word(kind_t k, logic present, logic [TAG_BITS-1:0] t,
                                     logic [PAYLOAD_BITS-1:0] pay);
    int s;
    case (k)
      KIND_REGISTER: if (present) s = enrol_tag(t);
      KIND_STORE: if (present) begin
        s = enrol_tag(t);
        if (s >= 0) begin
          held_payload[s] = pay;
          held_ready[s]   = 1'b1;
        end
      end
      KIND_TICK: tick_now = tick_now + 1'b1;
      default: release_walk();
    endcase
  endfunction

  always @(posedge clk) begin : watch
    release_word_t want;
    if (rst) begin
      head_slot     = 0;
      held_count    = 0;
      tick_now      = '0;
      timeout_ticks = TIMEOUT_RESET;
      held_ready    = '{default: 1'b0};
      rq_wr         = 0;
      rq_rd         = 0;
    end else begin
      if (cfg_we) timeout_ticks = cfg_wdata;
      // results first: a word leaving now belongs to an earlier collect
      if (result.valid && result.ready) begin
        if (rq_wr == rq_rd) begin
          err_total++;
          $display("%0t: unexpected release word, expected none", $time);
          $display("%0t:   got tag %h payload %h expired %b last %b",
                   $time, result.out_tag, result.out_payload, result.out_expired, result.last);
        end else begin
          want = release_buf[rq_rd % RQ_DEPTH];
          rq_rd++;
          if (want.tag !== result.out_tag || want.payload !== result.out_payload ||
              want.expired !== result.out_expired || want.last !== result.last) begin
            err_total++;
            $display("%0t: release mismatch: expected tag %h payload %h expired %b last %b",
                     $time, want.tag, want.payload, want.expired, want.last);
            $display("%0t:                   got      tag %h payload %h expired %b last %b",
                     $time, result.out_tag, result.out_payload, result.out_expired,
                     result.last);
          end
        end
      end
      if (item.valid && item.ready)
        apply_word(kind_t'(item.kind), item.tag_present, item.bag_tag, item.result_payload);
    end
    errors  <= err_total;
    pending <= rq_wr - rq_rd;
  end

endmodule

// ===== verif/tb_in_order_release_reorder_buffer.sv =====
// Testbench top for the in-order release reorder buffer: stimulus, idling, watchdog and verdict.
module tb_in_order_release_reorder_buffer;
  import rob_pkg::*;

  localparam int ITEM_TARGET = 420;
  localparam int PHASES      = 8;
  localparam int SETTLE      = 100;   // covers a full tag search or release walk
  localparam int QUIET_LIMIT = 5000;  // cycles with no word, config write or reset moving
  localparam int POOL        = 24;    // more tags than slots, so hits, misses and full all occur

  // timeout per random phase; the extremes 1 and all-ones are among them
  localparam logic [CFG_BITS-1:0] TIMEOUT_SET [PHASES] =
    '{32'd3, 32'hFFFF_FFFF, 32'd1, 32'd5, 32'd2, 32'd1000, 32'd8, 32'h8000_0001};

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int words_sent     = 0;
  int quiet_cycles   = 0;
  int err_count;
  int pending_cnt;

  logic [15:0] tag_pool [POOL];

  rob_in_if  item_ch ();
  rob_out_if res_ch ();

  in_order_release_reorder_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (res_ch)
  );

  rob_release_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (res_ch),
    .errors    (err_count),
    .pending   (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: one decision per cycle, so stalls land on every phase of the walk.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted word or config write counts as progress.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input word; random idle cycles first, then hold valid until ready.
  // Valid is left high on return so back-to-back words need no extra step.
  task automatic send_word(input kind_t k, input logic present, input logic [15:0] tag,
                           input logic [31:0] pay);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.kind           <= k;
    item_ch.tag_present    <= present;
    item_ch.bag_tag        <= tag;
    item_ch.result_payload <= pay;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    // words with tag_present clear on register/store are no-ops: not counted
    if (k == KIND_TICK || k == KIND_COLLECT || present) words_sent++;
  endtask

  // Tick or collect with junk in the fields the block must ignore.
  task automatic send_filler(input kind_t k);
    send_word(k, 1'($urandom_range(0, 1)), 16'($urandom), 32'($urandom));
  endtask

  task automatic send_ticks();
    if ($urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 3)) send_filler(KIND_TICK);
  endtask

  // Drain: every expected release out, then let a silent search or walk finish.
  task automatic quiesce();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [CFG_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_tag();
    return ($urandom_range(0, 9) < 9) ? tag_pool[$urandom_range(0, POOL - 1)] : 16'($urandom);
  endfunction

  // A well-formed batch: some tags registered, results stored out of order with
  // ticks in between, then one or two collects.
  task automatic run_transaction();
    logic [15:0] picks [6];
    int          n;
    int          start;
    n     = $urandom_range(1, 6);
    start = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      picks[i] = pick_tag();
      if ($urandom_range(0, 9) < 6) send_word(KIND_REGISTER, 1'b1, picks[i], 32'($urandom));
      send_ticks();
    end
    // some stores skipped: those entries wait for a later store or time out
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        send_word(KIND_STORE, 1'b1, picks[(i + start) % n], 32'($urandom));
        send_ticks();
      end
    end
    send_filler(KIND_COLLECT);
    if ($urandom_range(0, 9) < 3) send_filler(KIND_COLLECT);
  endtask

  initial begin
    int phase_goal;

    item_ch.valid          <= 1'b0;
    item_ch.kind           <= KIND_REGISTER;
    item_ch.tag_present    <= 1'b0;
    item_ch.bag_tag        <= '0;
    item_ch.result_payload <= '0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    rst                    <= 1'b1;

    // pool holds both all-zero and all-one tags
    tag_pool[0] = 16'h0000;
    tag_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL; i++) tag_pool[i] = 16'($urandom);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset timeout (1000): nothing can time out here ---
    send_word(KIND_REGISTER, 1'b1, 16'h0000, 32'($urandom));
    send_word(KIND_REGISTER, 1'b1, 16'h0000, 32'($urandom));     // duplicate tag: no new entry
    send_word(KIND_REGISTER, 1'b0, 16'h0007, 32'($urandom));     // tag absent: ignored
    send_word(KIND_STORE,    1'b0, 16'h0009, 32'hFFFF_FFFF);     // tag absent: ignored
    send_filler(KIND_COLLECT);                                   // head unready: no words
    send_word(KIND_STORE,    1'b1, 16'h0000, 32'h0000_0000);
    send_word(KIND_STORE,    1'b1, 16'h0000, 32'hFFFF_FFFF);     // second store overwrites
    // stores to unknown tags register them; fills the buffer to 16
    send_word(KIND_STORE,    1'b1, 16'hFFFF, 32'($urandom));
    for (int i = 1; i <= 14; i++) send_word(KIND_STORE, 1'b1, 16'(i), 32'($urandom));
    send_word(KIND_STORE,    1'b1, 16'h7777, 32'h1234_5678);     // full: dropped with payload
    send_word(KIND_REGISTER, 1'b1, 16'h7778, 32'($urandom));     // full: dropped
    send_filler(KIND_COLLECT);                                   // sixteen words in one collect

    // --- directed, shortest timeout: fail-safe releases ---
    quiesce();
    write_timeout(32'd1);
    send_word(KIND_REGISTER, 1'b1, 16'h00AA, 32'($urandom));
    send_word(KIND_TICK,     1'b1, 16'hFFFF, 32'hFFFF_FFFF);     // fields ignored on a tick
    send_word(KIND_REGISTER, 1'b1, 16'h00BB, 32'($urandom));
    send_filler(KIND_COLLECT);                                   // AA timed out, BB stops the walk
    send_word(KIND_STORE,    1'b1, 16'h00BB, 32'h5A5A_A5A5);
    send_filler(KIND_TICK);
    send_filler(KIND_COLLECT);                                   // ready wins over waited time
    send_filler(KIND_COLLECT);                                   // empty buffer: no words

    // --- random phases: idling mode cycles through four settings ---
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      write_timeout(TIMEOUT_SET[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      // running total, directed words included
      phase_goal = ((p + 1) * ITEM_TARGET) / PHASES;
      while (words_sent < phase_goal) begin
        if ($urandom_range(0, 9) < 8) begin
          run_transaction();
        end else begin
          // noise: any kind, tag often fresh or absent
          send_word(kind_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                    16'($urandom), 32'($urandom));
        end
      end
    end

    quiesce();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/rob_pkg.sv
design/rob_if.sv
design/rob_ram.sv
design/rob_ctrl.sv
design/rob_dp.sv
design/in_order_release_reorder_buffer.sv
verif/rob_release_checker.sv
verif/tb_in_order_release_reorder_buffer.sv
